[design/u8dec_pkg.sv]
// shared types and byte-class constants for the utf-8 byte stream decoder
`default_nettype none

package u8dec_pkg;

    localparam int CODE_W = 21;

    // lead byte classes: mask and tag per sequence length
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    // payload masks
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD4_BITS = 8'h07;
    localparam logic [7:0] FOLLOW_BITS = 8'h3F;

    // follow byte class
    localparam logic [7:0] FOLLOW_MASK = 8'hC0;
    localparam logic [7:0] FOLLOW_TAG  = 8'h80;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    typedef struct packed {
        logic [1:0]        pending;
        logic [CODE_W-1:0] acc;
        logic              bad;
    } dec_state_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              has_code;
        logic              string_end;
    } dec_result_t;

endpackage

`default_nettype wire

[design/u8dec_step.sv]
// per-byte decode step: next decoder state and the optional result word
`default_nettype none

module u8dec_step
    import u8dec_pkg::*;
(
    input  dec_state_t  state,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output dec_state_t  state_next,
    output dec_result_t result
);

    logic              emit;
    logic [CODE_W-1:0] code;
    logic              bad_n;
    logic [1:0]        pend_n;
    logic [CODE_W-1:0] acc_sh;
    dec_state_t        walk;

    assign bad_n  = state.bad | ((data_byte & FOLLOW_MASK) != FOLLOW_TAG);
    assign pend_n = state.pending - 2'd1;
    assign acc_sh = {state.acc[CODE_W-7:0], data_byte[5:0] & FOLLOW_BITS[5:0]};

    always_comb
    begin
        walk = state;
        emit = 1'b0;
        code = '0;
        if (state.pending == 2'd0)
        begin
            priority if (data_byte < ASCII_LIMIT)
            begin
                emit = 1'b1;
                code = CODE_W'(data_byte);
            end
            else if ((data_byte & LEAD2_MASK) == LEAD2_TAG)
            begin
                walk.acc     = CODE_W'(data_byte & LEAD2_BITS);
                walk.pending = 2'd1;
                walk.bad     = 1'b0;
            end
            else if ((data_byte & LEAD3_MASK) == LEAD3_TAG)
            begin
                walk.acc     = CODE_W'(data_byte & LEAD3_BITS);
                walk.pending = 2'd2;
                walk.bad     = 1'b0;
            end
            else if ((data_byte & LEAD4_MASK) == LEAD4_TAG)
            begin
                walk.acc     = CODE_W'(data_byte & LEAD4_BITS);
                walk.pending = 2'd3;
                walk.bad     = 1'b0;
            end
            else
            begin
                walk = state;  // stray lead, skipped
            end
        end
        else
        begin
            walk.pending = pend_n;
            walk.acc     = acc_sh;
            walk.bad     = bad_n;
            if (pend_n == 2'd0)
            begin
                emit     = !bad_n;
                code     = bad_n ? '0 : acc_sh;
                walk.acc = '0;
                walk.bad = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (last_byte)
        begin
            state_next        = '0;
            result.valid      = 1'b1;
            result.string_end = 1'b1;
        end
        else
        begin
            state_next        = walk;
            result.valid      = emit;
            result.string_end = 1'b0;
        end
        result.code     = code;
        result.has_code = emit;
    end

endmodule

`default_nettype wire

[design/utf8_byte_stream_decoder.sv]
// top level of the utf-8 byte stream decoder: input stage, decoder state, result register
//
//  channel | direction | handshake            | word fields
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_stall  | data_byte[7:0], last_byte
//  out     | output    | out_valid / out_stall| code_point[20:0], has_code, string_end
//
//  one byte is taken each cycle unless in_stall is high; byte and result are registered
//  the rate is set by the single decode step between the input stage and result register
//  a byte that gives no result moves on even while the result register is stalled
//  a byte that gives a result waits in the input stage while a result is held by out_stall
//  rst_n clears the decoder state and both valid flags asynchronously
`default_nettype none

module utf8_byte_stream_decoder
    import u8dec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_stall,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output      logic              out_valid,
    input  wire logic              out_stall,
    output      logic [CODE_W-1:0] code_point,
    output      logic              has_code,
    output      logic              string_end
);

    // input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // decoder state
    dec_state_t  state_reg;
    dec_state_t  state_next;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t out_word_reg;

    dec_result_t step_res;
    logic        out_free;
    logic        s1_fire;
    logic        in_take;

    u8dec_step u_step (
        .state      (state_reg),
        .data_byte  (s1_byte_reg),
        .last_byte  (s1_last_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // result slot can take a word when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // a staged byte moves on unless its result has nowhere to go
    assign s1_fire  = s1_valid_reg && (!step_res.valid || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (out_free)
            out_valid_next = s1_fire && step_res.valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (out_free && s1_fire && step_res.valid)
            out_word_reg <= step_res;
    end

    assign out_valid  = out_valid_reg;
    assign code_point = out_word_reg.code;
    assign has_code   = out_word_reg.has_code;
    assign string_end = out_word_reg.string_end;

    // the end of a string leaves the decoder in its reset state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> state_reg == '0)
        else $error("decoder state not cleared after string end");

    // a word without a code point only comes from the string end, with a zero code
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_code |-> string_end && code_point == '0)
        else $error("empty result word without string end");

    // the input side only stalls on a staged byte whose result is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    // a held result word is not overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word_reg))
        else $error("stalled result word changed");

endmodule

`default_nettype wire

[tb/utf8_byte_stream_decoder_test.sv]
// testbench for the utf-8 byte stream decoder: directed and random byte strings, scoreboard check
module utf8_byte_stream_decoder_test;
    import u8dec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int RANDOM_WORDS  = 1550;
    localparam int DRAIN_CYCLES  = 6;    // slack after the expected words have come back
    localparam int HOLD_OFF_LEN  = 150;
    localparam int REPORT_LIMIT  = 10;

    // one decoded character (or empty end marker) as the block should deliver it
    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              has_code;
        logic              string_end;
    } glyph_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        data_byte = 8'h00;
    logic              last_byte = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CODE_W-1:0] code_point;
    logic              has_code;
    logic              string_end;

    // decoder state as the predictor tracks it
    logic [1:0]        follow_left = 2'd0;
    logic [CODE_W-1:0] code_acc = '0;
    logic              seq_broken = 1'b0;

    glyph_t pending_glyphs[$];

    int cycle_count = 0;
    int words_sent = 0;
    int strings_sent = 0;
    int glyphs_checked = 0;
    int mismatch_count = 0;
    int hold_off_len = 0;      // set by a test, consumed by the receiver process
    bit quiet = 1'b0;          // no gaps on either side while set

    utf8_byte_stream_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .has_code   (has_code),
        .string_end (string_end)
    );

    always #5 clk = ~clk;

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // add one expected result word at the tail of the scoreboard queue
    function automatic void queue_glyph(input glyph_t g);
        pending_glyphs.insert(pending_glyphs.size(), g);
    endfunction

    // add one byte at the end of a string under construction
    function automatic void append_byte(ref logic [7:0] text[$], input logic [7:0] b);
        text.insert(text.size(), b);
    endfunction

    // advance the predicted decoder by one accepted byte and queue any result it causes
    task automatic decode_expect(input logic [7:0] b, input logic is_last);
        logic              emit;
        logic [CODE_W-1:0] code;
        glyph_t            g;
        emit = 1'b0;
        code = '0;
        if (follow_left == 2'd0)
        begin
            if (b < ASCII_LIMIT)
            begin
                emit = 1'b1;
                code = CODE_W'(b);
            end
            else if ((b & LEAD2_MASK) == LEAD2_TAG)
            begin
                code_acc = CODE_W'(b & LEAD2_BITS);
                follow_left = 2'd1;
                seq_broken = 1'b0;
            end
            else if ((b & LEAD3_MASK) == LEAD3_TAG)
            begin
                code_acc = CODE_W'(b & LEAD3_BITS);
                follow_left = 2'd2;
                seq_broken = 1'b0;
            end
            else if ((b & LEAD4_MASK) == LEAD4_TAG)
            begin
                code_acc = CODE_W'(b & LEAD4_BITS);
                follow_left = 2'd3;
                seq_broken = 1'b0;
            end
            // anything else in lead position is a stray byte and is skipped
        end
        else
        begin
            if ((b & FOLLOW_MASK) != FOLLOW_TAG)
                seq_broken = 1'b1;
            // follow bytes are taken whatever they hold
            code_acc = {code_acc[CODE_W-7:0], b[5:0]};
            follow_left = follow_left - 2'd1;
            if (follow_left == 2'd0)
            begin
                if (!seq_broken)
                begin
                    emit = 1'b1;
                    code = code_acc;
                end
                code_acc = '0;
                seq_broken = 1'b0;
            end
        end

        if (is_last)
        begin
            // end of string: always one result, any unfinished sequence is dropped
            follow_left = 2'd0;
            code_acc = '0;
            seq_broken = 1'b0;
            g.code_point = emit ? code : '0;
            g.has_code = emit;
            g.string_end = 1'b1;
            queue_glyph(g);
        end
        else if (emit)
        begin
            g.code_point = code;
            g.has_code = 1'b1;
            g.string_end = 1'b0;
            queue_glyph(g);
        end
    endtask

    // scoreboard: predict on every accepted input word, check every accepted output word
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                decode_expect(data_byte, last_byte);
            if (out_valid && !out_stall)
            begin
                if (pending_glyphs.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected word: code_point=%h has_code=%b string_end=%b",
                                 code_point, has_code, string_end);
                end
                else
                begin
                    want = pending_glyphs.pop_front();
                    glyphs_checked++;
                    if (code_point !== want.code_point || has_code !== want.has_code
                        || string_end !== want.string_end)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("word %0d: expected %h/%b/%b, got %h/%b/%b",
                                     glyphs_checked, want.code_point, want.has_code,
                                     want.string_end, code_point, has_code, string_end);
                    end
                end
            end
        end
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_glyphs.size());
            $display("utf8_byte_stream_decoder: mismatch");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold-off when a test asks for one
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                out_stall <= 1'b0;
            end
            else if (rst_n && $urandom_range(0, 3) == 0)
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // offer one byte after an optional gap and hold it until the block takes it
    task automatic send_word(input logic [7:0] b, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (is_last)
            strings_sent++;
    endtask

    // send a whole string, the end mark going on its final byte
    task automatic send_text(input logic [7:0] text[$]);
        for (int i = 0; i < text.size(); i++)
            send_word(text[i], i == text.size() - 1);
    endtask

    // stop offering and wait until every expected word has come back
    // the scoreboard predicts the last accepted byte at a clock edge before the wait begins
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_glyphs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ascii extremes, one of them ending a string
    task automatic test_ascii();
        send_text('{8'h00, 8'h7F});
    endtask

    // low and high values of the two- and three-byte lengths, and the largest four-byte value
    task automatic test_multi_byte();
        send_text('{8'hC2, 8'h80, 8'hDF, 8'hBF});
        send_text('{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF});
        send_text('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
    endtask

    // stray leads are skipped; a stray as the last byte still gives an empty end word
    task automatic test_stray_lead();
        send_text('{8'hBF, 8'hF8, 8'hFF});
    endtask

    // broken follow byte: sequence swallows its full length, then vanishes
    task automatic test_bad_sequence();
        send_word(8'hE2, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'h82, 1'b0);
        // broken sequence whose final byte ends the string
        send_text('{8'hC3, 8'hC3});
    endtask

    // string ends in the middle of a sequence
    task automatic test_cut_off();
        send_text('{8'hF0, 8'h9F});
    endtask

    // receiver holds off while ascii keeps coming, so the block fills and stalls its input
    task automatic test_hold_off();
        logic [7:0] text[$];
        wait_drained();
        for (int i = 0; i < 40; i++)
            append_byte(text, 8'($urandom_range(0, 127)));
        quiet = 1'b1;
        hold_off_len = HOLD_OFF_LEN;
        @(posedge clk);
        send_text(text);
        while (hold_off_len != 0)
            @(posedge clk);
        quiet = 1'b0;
        wait_drained();
    endtask

    // one well-formed sequence of random length with random payload
    task automatic add_sequence(ref logic [7:0] text[$]);
        int len;
        len = $urandom_range(1, 4);
        case (len)
            1: append_byte(text, 8'($urandom_range(0, 127)));
            2: append_byte(text, LEAD2_TAG | 8'($urandom_range(0, 31)));
            3: append_byte(text, LEAD3_TAG | 8'($urandom_range(0, 15)));
            default: append_byte(text, LEAD4_TAG | 8'($urandom_range(0, 7)));
        endcase
        for (int i = 1; i < len; i++)
            append_byte(text, FOLLOW_TAG | 8'($urandom_range(0, 63)));
    endtask

    // random strings: mostly well-formed, some noise, broken and cut-off sequences
    task automatic test_random();
        logic [7:0] text[$];
        int units;
        int r;
        int pos;
        int next_pause;
        next_pause = words_sent + 200;
        while (words_sent < RANDOM_WORDS)
        begin
            text.delete();
            units = $urandom_range(1, 10);
            for (int u = 0; u < units; u++)
            begin
                r = $urandom_range(0, 99);
                if (r < 78)
                    add_sequence(text);
                else if (r < 88)
                    append_byte(text, 8'($urandom_range(0, 255)));
                else
                begin
                    // corrupt one byte of a sequence
                    pos = text.size();
                    add_sequence(text);
                    pos = $urandom_range(pos, text.size() - 1);
                    text[pos] = 8'($urandom_range(0, 255));
                end
            end
            // sometimes cut the string short by its final byte
            if ($urandom_range(0, 5) == 0 && text.size() > 1)
                void'(text.pop_back());
            send_text(text);

            // alternate stretches with and without gaps, and pause now and then
            if ($urandom_range(0, 15) == 0)
                quiet = !quiet;
            if (words_sent >= next_pause)
            begin
                wait_drained();
                next_pause = words_sent + 200;
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_ascii();
        test_multi_byte();
        test_stray_lead();
        test_bad_sequence();
        test_cut_off();
        test_hold_off();
        test_random();

        // let the tail of the results come out, then a few idle cycles for strays
        wait_drained();

        $display("ran %0d words in %0d strings, %0d results checked", words_sent,
                 strings_sent, glyphs_checked);
        $display("covered all lead lengths, stray leads, broken and cut-off sequences, stalls");
        if (mismatch_count == 0 && pending_glyphs.size() == 0)
            $display("utf8_byte_stream_decoder: match");
        else
            $display("utf8_byte_stream_decoder: mismatch");
        $finish;
    end

endmodule
